// ===== rtl/wors_pkg.sv =====
// Shared constants and types for the write-once row store checker.
package wors_pkg;

    localparam int ROWS       = 1024;
    localparam int COORDS     = 3;

    localparam int ROW_W      = 10;
    localparam int COORD_W    = 32;
    localparam int IN_COORDS  = 3;
    localparam int DISC_W     = 32;
    localparam int ADDR_W     = $clog2(ROWS);
    localparam int COUNT_W    = $clog2(ROWS + 1);

    localparam int IN_DATA_W  = ((ROW_W + IN_COORDS * COORD_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((DISC_W + COUNT_W + 7) / 8) * 8;
    localparam int OUT_USER_W = 2;

    // tuser bit positions on the result side
    localparam int USER_FIRST = 0;
    localparam int USER_BAD   = 1;

    typedef logic [COORDS-1:0][COORD_W-1:0] point_t;

    typedef struct packed {
        logic              valid;
        logic [DISC_W-1:0] max_diff;
    } meta_t;

    localparam int META_W  = $bits(meta_t);
    localparam int POINT_W = $bits(point_t);

endpackage

// ===== rtl/write_once_row_store_checker.sv =====
// Top level: write-once row store with per-row maximum discrepancy tracking.
// A request's RAM read is registered alongside the s1 registers; fold/writeback then loads the
//   result register that drives m_tvalid, unless an untaken result stalls s1.
// Throughput: one request per cycle unless a held result stalls s1; a row's fold and writeback
//   happen as s1 advances, and a one-entry forward of the last writeback covers back-to-back rows.
// Reset: control clears at once; then a clearing pass over all ROWS (1024) addresses zeroes the
//   valid/max RAM, with s_tready low throughout. Point RAM is never cleared.
module write_once_row_store_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    // request side
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // row_index[9:0], point_x[41:10], point_y[73:42], point_z[105:74], zero pad
    input  logic [wors_pkg::IN_DATA_W-1:0]      s_tdata,
    // result side
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // row_discrepancy[31:0], rows_filled[42:32], zero pad
    output logic [wors_pkg::OUT_DATA_W-1:0]     m_tdata,
    // first_write[0], bad_row[1]
    output logic [wors_pkg::OUT_USER_W-1:0]     m_tuser
);

    // ---------------------------------------------------------------
    // Request unpacking
    // ---------------------------------------------------------------
    logic [wors_pkg::ROW_W-1:0]  s_row;
    wors_pkg::point_t            s_point;
    logic                        s_bad;

    assign s_row = s_tdata[wors_pkg::ROW_W-1:0];

    always_comb
    begin
        for (int c = 0; c < wors_pkg::COORDS; c++)
        begin
            s_point[c] = s_tdata[wors_pkg::ROW_W + c * wors_pkg::COORD_W +: wors_pkg::COORD_W];
        end
    end

    // row beyond the store: flagged, nothing touched
    assign s_bad = (32'(s_row) >= 32'(wors_pkg::ROWS));

    // ---------------------------------------------------------------
    // Clearing pass of the valid/max RAM after reset
    // ---------------------------------------------------------------
    logic                          clr_active_reg, clr_active_next;
    logic [wors_pkg::ADDR_W-1:0]   clr_addr_reg, clr_addr_next;

    always_comb
    begin
        clr_active_next = clr_active_reg;
        clr_addr_next   = clr_addr_reg;
        if (clr_active_reg)
        begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (clr_addr_reg == (wors_pkg::ADDR_W)'(wors_pkg::ROWS - 1))
            begin
                clr_active_next = 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // Handshake and pipeline control
    // ---------------------------------------------------------------
    logic                          s1_valid_reg, s1_valid_next;
    logic [wors_pkg::ADDR_W-1:0]   s1_row_reg;
    logic                          s1_bad_reg;
    wors_pkg::point_t              s1_point_reg;

    logic                          m_tvalid_reg, m_tvalid_next;
    logic                          out_free;
    logic                          s1_adv;
    logic                          accept;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s1_adv   = s1_valid_reg && out_free;
    // output register parts the sides: a new request enters while a result waits
    assign s_tready = !clr_active_reg && (!s1_valid_reg || s1_adv);
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end
    end

    // ---------------------------------------------------------------
    // Memories: valid+max per row, stored point per row
    // ---------------------------------------------------------------
    logic                          meta_we;
    logic [wors_pkg::ADDR_W-1:0]   meta_waddr;
    wors_pkg::meta_t               meta_wdata;
    wors_pkg::meta_t               meta_rdata;
    logic                          point_we;
    wors_pkg::point_t              point_rdata;

    wors_ram #(
        .WIDTH (wors_pkg::META_W),
        .DEPTH (wors_pkg::ROWS)
    ) u_meta_ram (
        .clk   (clk),
        .we    (meta_we),
        .waddr (meta_waddr),
        .wdata (meta_wdata),
        .re    (accept),
        .raddr ((wors_pkg::ADDR_W)'(s_row)),
        .rdata (meta_rdata)
    );

    wors_ram #(
        .WIDTH (wors_pkg::POINT_W),
        .DEPTH (wors_pkg::ROWS)
    ) u_point_ram (
        .clk   (clk),
        .we    (point_we),
        .waddr (s1_row_reg),
        .wdata (s1_point_reg),
        .re    (accept),
        .raddr ((wors_pkg::ADDR_W)'(s_row)),
        .rdata (point_rdata)
    );

    // ---------------------------------------------------------------
    // Fold stage with forwarding of the last writeback.
    // The RAM read issued on the same edge as a writeback returns the old
    // word, so the previous write is kept and used on an address match.
    // ---------------------------------------------------------------
    logic                          fwd_valid_reg;
    logic [wors_pkg::ADDR_W-1:0]   fwd_addr_reg;
    wors_pkg::meta_t               fwd_meta_reg;
    wors_pkg::point_t              fwd_point_reg;

    logic                          fwd_hit;
    wors_pkg::meta_t               meta_cur;
    wors_pkg::point_t              point_cur;
    logic                          first;
    logic [wors_pkg::DISC_W-1:0]   fold_max;
    wors_pkg::meta_t               meta_new;
    wors_pkg::point_t              point_new;
    logic                          row_wr;

    assign fwd_hit   = fwd_valid_reg && (fwd_addr_reg == s1_row_reg);
    assign meta_cur  = fwd_hit ? fwd_meta_reg : meta_rdata;
    assign point_cur = fwd_hit ? fwd_point_reg : point_rdata;
    // stored point is only looked at once the row is valid
    assign first     = !meta_cur.valid;

    wors_fold u_fold (
        .stored   (point_cur),
        .incoming (s1_point_reg),
        .old_max  (meta_cur.max_diff),
        .new_max  (fold_max)
    );

    always_comb
    begin
        meta_new.valid    = 1'b1;
        meta_new.max_diff = first ? meta_cur.max_diff : fold_max;
        point_new         = first ? s1_point_reg : point_cur;
    end

    assign row_wr   = s1_adv && !s1_bad_reg;
    assign point_we = row_wr && first;

    // clearing pass owns the write port while it runs; no request is in flight then
    always_comb
    begin
        if (clr_active_reg)
        begin
            meta_we    = 1'b1;
            meta_waddr = clr_addr_reg;
            meta_wdata = '0;
        end
        else
        begin
            meta_we    = row_wr;
            meta_waddr = s1_row_reg;
            meta_wdata = meta_new;
        end
    end

    // ---------------------------------------------------------------
    // Filled-row count and result register
    // ---------------------------------------------------------------
    logic [wors_pkg::COUNT_W-1:0]  count_reg, count_next;
    logic [wors_pkg::DISC_W-1:0]   res_disc_reg;
    logic [wors_pkg::COUNT_W-1:0]  res_count_reg;
    logic                          res_first_reg;
    logic                          res_bad_reg;

    always_comb
    begin
        count_next = count_reg;
        if (point_we)
        begin
            count_next = count_reg + 1'b1;
        end
    end

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (s1_adv)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
            s1_valid_reg   <= 1'b0;
            m_tvalid_reg   <= 1'b0;
            fwd_valid_reg  <= 1'b0;
            count_reg      <= '0;
        end
        else
        begin
            clr_active_reg <= clr_active_next;
            clr_addr_reg   <= clr_addr_next;
            s1_valid_reg   <= s1_valid_next;
            m_tvalid_reg   <= m_tvalid_next;
            count_reg      <= count_next;
            if (row_wr)
            begin
                fwd_valid_reg <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_row_reg   <= (wors_pkg::ADDR_W)'(s_row);
            s1_bad_reg   <= s_bad;
            s1_point_reg <= s_point;
        end
        if (row_wr)
        begin
            fwd_addr_reg  <= s1_row_reg;
            fwd_meta_reg  <= meta_new;
            fwd_point_reg <= point_new;
        end
        if (s1_adv)
        begin
            res_disc_reg  <= s1_bad_reg ? '0 : meta_new.max_diff;
            res_count_reg <= count_next;
            res_first_reg <= first && !s1_bad_reg;
            res_bad_reg   <= s1_bad_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = (wors_pkg::OUT_DATA_W)'({res_count_reg, res_disc_reg});

    always_comb
    begin
        m_tuser                      = '0;
        m_tuser[wors_pkg::USER_FIRST] = res_first_reg;
        m_tuser[wors_pkg::USER_BAD]   = res_bad_reg;
    end

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    // no request enters while the clearing pass runs
    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clr_active_reg |-> !s_tready)
        else $error("request accepted during clearing pass");

    // count never passes the number of rows
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= 32'(wors_pkg::ROWS))
        else $error("filled-row count beyond store size");

    // a first write grows the count by exactly one
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        point_we |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("filled-row count did not step on first write");

    // a first write reports a zero discrepancy
    a_first_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid_reg && res_first_reg) |-> (res_disc_reg == '0))
        else $error("first write with nonzero discrepancy");

endmodule

// ===== rtl/wors_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module wors_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/wors_fold.sv =====
// Folds the largest absolute coordinate difference into a running maximum.
module wors_fold (
    input  wors_pkg::point_t                  stored,
    input  wors_pkg::point_t                  incoming,
    input  logic [wors_pkg::DISC_W-1:0]       old_max,
    output logic [wors_pkg::DISC_W-1:0]       new_max
);

    logic [wors_pkg::COORDS-1:0][wors_pkg::DISC_W-1:0] diff;

    // 33-bit signed difference; its magnitude always fits 32 bits
    always_comb
    begin
        logic signed [wors_pkg::COORD_W:0] d;
        for (int c = 0; c < wors_pkg::COORDS; c++)
        begin
            d = {stored[c][wors_pkg::COORD_W-1], stored[c]}
              - {incoming[c][wors_pkg::COORD_W-1], incoming[c]};
            diff[c] = d[wors_pkg::COORD_W] ? wors_pkg::DISC_W'(-d)
                                            : wors_pkg::DISC_W'(d);
        end
    end

    always_comb
    begin
        logic [wors_pkg::DISC_W-1:0] m;
        m = old_max;
        for (int c = 0; c < wors_pkg::COORDS; c++)
        begin
            if (diff[c] > m)
            begin
                m = diff[c];
            end
        end
        new_max = m;
    end

endmodule
